// ----- src/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define GTP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define GTP_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define GTP_ASSERT(lbl, clk, rst_n, prop)
`define GTP_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ----- src/gtp_pkg.sv -----
package gtp_pkg;

  localparam logic [3:0] REG_IMAGE_SIZE   = 4'd0;
  localparam logic [3:0] REG_TINT_HASH    = 4'd1;
  localparam logic [3:0] REG_STEM_LOW     = 4'd2;
  localparam logic [3:0] REG_STEM_HIGH    = 4'd3;
  localparam logic [3:0] REG_STEM_LENGTH  = 4'd4;
  localparam logic [3:0] REG_LABEL_LOW    = 4'd5;
  localparam logic [3:0] REG_LABEL_HIGH   = 4'd6;
  localparam logic [3:0] REG_LABEL_LENGTH = 4'd7;

  typedef enum logic [2:0] {
    ST_READY, ST_S1, ST_S2, ST_MG, ST_M1, ST_M2, ST_LAYOUT
  } cfg_state_t;

  typedef struct packed {
    logic         en;
    logic [4:0]   n;
    logic [12:0]  x0;
    logic [12:0]  y0;
    logic [25:0]  m;
    logic [127:0] chars;
  } line_t;

  typedef struct packed {
    logic [12:0]      w;
    logic [12:0]      border;
    logic [12:0]      wb;
    logic [2:0][7:0]  dark;
    logic [2:0][7:0]  diff;
    logic [31:0]      mg;
    line_t [1:0]      line;
  } geo_t;

endpackage

// ----- src/gtp_pix_if.sv -----
interface gtp_pix_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  modport source(output valid, pixel_x, pixel_y, input ready);
  modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface

// ----- src/gtp_rgb_if.sv -----
interface gtp_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

// ----- src/gtp_cfg_if.sv -----
interface gtp_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- src/gtp_div.sv -----
`include "assert_macros.svh"
module gtp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [36:0] dividend,
  input  logic [13:0] divisor,
  output logic        done,
  output logic [36:0] quotient
);

  logic [13:0] rem_r;
  logic [36:0] quo_r;
  logic [13:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [14:0] trial;
  logic        take;

  assign trial = {rem_r, quo_r[36]};
  assign take  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 6'd37;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 6'd1;
      busy_r <= cnt_r != 6'd1;
      done_r <= cnt_r == 6'd1;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 14'd0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? 14'(trial - {1'b0, dvs_r}) : trial[13:0];
      quo_r <= {quo_r[35:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  `GTP_ASSERT(a_done_after_busy, clk, rst_n, done_r |-> $past(busy_r))

endmodule

// ----- src/gtp_cfg.sv -----
`include "assert_macros.svh"
module gtp_cfg import gtp_pkg::*; #(
  parameter int MAX_SIZE     = 4096,
  parameter int MAX_LINE_LEN = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        cfg_ready,
  output geo_t        geo,
  output logic        geo_ok
);

  logic [12:0]  image_size_r;
  logic [31:0]  tint_hash_r;
  logic [127:0] stem_chars_r;
  logic [4:0]   stem_length_r;
  logic [127:0] label_chars_r;
  logic [4:0]   label_length_r;

  cfg_state_t   state_r, state_nxt;
  logic         pend_r;
  logic [11:0]  s1_r, s2_r;
  logic [31:0]  mg_r;
  logic [25:0]  m1_r, m2_r;
  geo_t         geo_r, geo_nxt;

  logic         wr;
  logic [12:0]  w;
  logic [4:0]   n1, n2;
  logic [14:0]  a;
  logic [5:0]   d1, d2;
  logic         div_start, div_done;
  logic [36:0]  div_dividend, div_quotient;
  logic [13:0]  div_divisor;
  logic [11:0]  s_q;

  logic [17:0]  tot1, tot2;
  logic         lv1, lv2, on;
  logic [14:0]  h1, h2;
  logic [11:0]  gap;
  logic [15:0]  stack;
  logic [12:0]  y1, y2;
  logic [2:0][7:0] full;
  logic [12:0]  brd;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r   <= 13'd256;
      tint_hash_r    <= 32'd0;
      stem_chars_r   <= 128'd0;
      stem_length_r  <= 5'd0;
      label_chars_r  <= 128'd0;
      label_length_r <= 5'd0;
    end else if (wr) begin
      unique case (cfg_index)
        REG_IMAGE_SIZE:   image_size_r          <= cfg_data[12:0];
        REG_TINT_HASH:    tint_hash_r           <= cfg_data[31:0];
        REG_STEM_LOW:     stem_chars_r[63:0]    <= cfg_data;
        REG_STEM_HIGH:    stem_chars_r[127:64]  <= cfg_data;
        REG_STEM_LENGTH:  stem_length_r         <= cfg_data[4:0];
        REG_LABEL_LOW:    label_chars_r[63:0]   <= cfg_data;
        REG_LABEL_HIGH:   label_chars_r[127:64] <= cfg_data;
        REG_LABEL_LENGTH: label_length_r        <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_size_r < 13'd16) begin
      w = 13'd16;
    end else if (32'(image_size_r) > MAX_SIZE) begin
      w = 13'(MAX_SIZE);
    end else begin
      w = image_size_r;
    end
  end

  assign n1 = (32'(stem_length_r) > MAX_LINE_LEN) ? 5'(MAX_LINE_LEN) : stem_length_r;
  assign n2 = (32'(label_length_r) > MAX_LINE_LEN) ? 5'(MAX_LINE_LEN) : label_length_r;
  // 4w/5 by reciprocal, exact below 2^16
  assign a  = 15'((32'({w, 2'b00}) * 32'd52429) >> 18);
  assign d1 = 6'({n1, 2'b00} - 7'd1);
  assign d2 = 6'({n2, 2'b00} - 7'd1);

  always_comb begin
    state_nxt = state_r;
    if (wr) begin
      state_nxt = ST_S1;
    end else begin
      unique case (state_r)
        ST_READY:  state_nxt = ST_READY;
        ST_S1:     if (div_done && pend_r) state_nxt = ST_S2;
        ST_S2:     if (div_done && pend_r) state_nxt = ST_MG;
        ST_MG:     if (div_done && pend_r) state_nxt = ST_M1;
        ST_M1:     if (div_done && pend_r) state_nxt = ST_M2;
        ST_M2:     if (div_done && pend_r) state_nxt = ST_LAYOUT;
        ST_LAYOUT: state_nxt = ST_READY;
        default:   state_nxt = ST_S1;
      endcase
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = 37'd0;
    div_divisor  = 14'd1;
    unique case (state_r)
      ST_S1: begin
        div_start    = !pend_r && !wr;
        div_dividend = 37'(a);
        div_divisor  = 14'(d1);
      end
      ST_S2: begin
        div_start    = !pend_r && !wr;
        div_dividend = 37'(a);
        div_divisor  = 14'(d2);
      end
      ST_MG: begin
        div_start    = !pend_r && !wr;
        div_dividend = 37'h10_0000_0000 + 37'({w, 1'b0}) - 37'd1;
        div_divisor  = {w, 1'b0};
      end
      ST_M1: begin
        div_start    = !pend_r && !wr;
        div_dividend = 37'd33554432 + 37'(s1_r) - 37'd1;
        div_divisor  = 14'(s1_r);
      end
      ST_M2: begin
        div_start    = !pend_r && !wr;
        div_dividend = 37'd33554432 + 37'(s2_r) - 37'd1;
        div_divisor  = 14'(s2_r);
      end
      default: ;
    endcase
  end

  gtp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign s_q = (div_quotient[11:0] == 12'd0) ? 12'd1 : div_quotient[11:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_S1;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr) begin
        pend_r <= 1'b0;
      end else if (div_start) begin
        pend_r <= 1'b1;
      end else if (div_done) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_done && pend_r && !wr) begin
      unique case (state_r)
        ST_S1:   s1_r <= (n1 == 5'd0) ? 12'd0 : s_q;
        ST_S2:   s2_r <= (n2 == 5'd0) ? 12'd0 : s_q;
        ST_MG:   mg_r <= div_quotient[31:0];
        ST_M1:   m1_r <= div_quotient[25:0];
        ST_M2:   m2_r <= div_quotient[25:0];
        default: ;
      endcase
    end
    if (state_r == ST_LAYOUT) begin
      geo_r <= geo_nxt;
    end
  end

  // layout of the two lines
  always_comb begin
    tot1  = 18'(d1) * 18'(s1_r);
    tot2  = 18'(d2) * 18'(s2_r);
    lv1   = (n1 != 5'd0) && (tot1 < 18'(w));
    lv2   = (n2 != 5'd0) && (tot2 < 18'(w));
    h1    = 15'(s1_r) * 15'd5;
    h2    = 15'(s2_r) * 15'd5;
    gap   = (s1_r > s2_r) ? s1_r : s2_r;
    stack = 16'(h1) + 16'(h2) + 16'(gap);
    on    = stack <= 16'(w);
    y1    = 13'((16'(w) - stack) >> 1);
    y2    = 13'(16'(y1) + 16'(h1) + 16'(gap));
    brd   = (w[12:6] < 7'd2) ? 13'd2 : 13'(w[12:6]);
    for (int i = 0; i < 3; i++) begin
      full[i] = 8'd80 + {1'b0, tint_hash_r[8*i +: 7]};
    end
    geo_nxt.w      = w;
    geo_nxt.border = brd;
    geo_nxt.wb     = w - brd;
    for (int i = 0; i < 3; i++) begin
      geo_nxt.dark[i] = 8'((18'(full[i]) * 18'd171) >> 10);
      geo_nxt.diff[i] = full[i] - geo_nxt.dark[i];
    end
    geo_nxt.mg            = mg_r;
    geo_nxt.line[0].en    = on && lv1;
    geo_nxt.line[0].n     = n1;
    geo_nxt.line[0].x0    = 13'((w - 13'(tot1)) >> 1);
    geo_nxt.line[0].y0    = y1;
    geo_nxt.line[0].m     = m1_r;
    geo_nxt.line[0].chars = stem_chars_r;
    geo_nxt.line[1].en    = on && lv2;
    geo_nxt.line[1].n     = n2;
    geo_nxt.line[1].x0    = 13'((w - 13'(tot2)) >> 1);
    geo_nxt.line[1].y0    = y2;
    geo_nxt.line[1].m     = m2_r;
    geo_nxt.line[1].chars = label_chars_r;
  end

  assign geo    = geo_r;
  assign geo_ok = state_r == ST_READY;

  `GTP_ASSERT(a_cfg_restarts, clk, rst_n, wr |=> (state_r == ST_S1))

endmodule

// ----- src/gtp_pipe.sv -----
`include "assert_macros.svh"
module gtp_pipe import gtp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  input  geo_t        geo,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  localparam logic [14:0] LETTERS [0:25] = '{
    15'o25755, 15'o65656, 15'o74447, 15'o65556, 15'o74647, 15'o74644, 15'o74557,
    15'o55755, 15'o72227, 15'o71157, 15'o56465, 15'o44447, 15'o57755, 15'o57775,
    15'o75557, 15'o75744, 15'o75573, 15'o75655, 15'o74717, 15'o72222, 15'o55557,
    15'o55552, 15'o55775, 15'o55255, 15'o55222, 15'o71247
  };
  localparam logic [14:0] DIGITS [0:9] = '{
    15'o75557, 15'o26227, 15'o71747, 15'o71717, 15'o55711,
    15'o74717, 15'o74757, 15'o71222, 15'o75757, 15'o75717
  };

  function automatic logic [14:0] glyph_bits(input logic [7:0] c);
    logic [7:0]  off;
    logic [14:0] g;
    off = 8'd0;
    g   = 15'o77777;
    if (c >= 8'h61 && c <= 8'h7a) begin
      off = c - 8'h61;
      g   = LETTERS[off[4:0]];
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      off = c - 8'h41;
      g   = LETTERS[off[4:0]];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      off = c - 8'h30;
      g   = DIGITS[off[3:0]];
    end else if (c == 8'h20) begin
      g = 15'o0;
    end else if (c == 8'h2e) begin
      g = 15'o2;
    end else if (c == 8'h2d) begin
      g = 15'o700;
    end else if (c == 8'h5f) begin
      g = 15'o7;
    end
    return g;
  endfunction

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1
  logic             out1_r, brd1_r;
  logic [12:0]      t1_r;
  logic [1:0]       ge1_r;
  logic [1:0][11:0] relx1_r, rely1_r;
  // stage 2
  logic             out2_r, brd2_r;
  logic [2:0][20:0] np2_r;
  logic [1:0]       ge2_r;
  logic [1:0][11:0] pc2_r, pr2_r;
  // stage 3
  logic             out3_r, brd3_r;
  logic [2:0][7:0]  g3_r;
  logic [1:0]       hit3_r;
  // stage 4
  logic [7:0]       red_r, green_r, blue_r;

  logic [12:0]      x13, y13;
  logic [1:0][37:0] px, py;
  logic [2:0][52:0] pg;
  logic [1:0]       hit;
  logic [1:0][7:0]  ch;
  logic [1:0][15:0] gl;
  logic [1:0][3:0]  bi;
  logic [2:0][7:0]  rgb;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign x13 = {1'b0, pixel_x};
  assign y13 = {1'b0, pixel_y};

  always_ff @(posedge clk) begin
    if (rdy1) begin
      out1_r <= (x13 >= geo.w) || (y13 >= geo.w);
      brd1_r <= (x13 < geo.border) || (y13 < geo.border) ||
                (x13 >= geo.wb) || (y13 >= geo.wb);
      t1_r   <= x13 + y13;
      for (int l = 0; l < 2; l++) begin
        ge1_r[l]   <= geo.line[l].en && (x13 >= geo.line[l].x0) && (y13 >= geo.line[l].y0);
        relx1_r[l] <= 12'(x13 - geo.line[l].x0);
        rely1_r[l] <= 12'(y13 - geo.line[l].y0);
      end
    end
  end

  // stage 2: gradient numerators and cell positions
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      px[l] = 38'(relx1_r[l]) * 38'(geo.line[l].m);
      py[l] = 38'(rely1_r[l]) * 38'(geo.line[l].m);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      out2_r <= out1_r;
      brd2_r <= brd1_r;
      ge2_r  <= ge1_r;
      for (int i = 0; i < 3; i++) begin
        np2_r[i] <= 21'(geo.diff[i]) * 21'(t1_r);
      end
      for (int l = 0; l < 2; l++) begin
        pc2_r[l] <= px[l][36:25];
        pr2_r[l] <= py[l][36:25];
      end
    end
  end

  // stage 3: gradient quotient and glyph hits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pg[i] = 53'(np2_r[i]) * 53'(geo.mg);
    end
    for (int l = 0; l < 2; l++) begin
      ch[l]  = geo.line[l].chars[{pc2_r[l][5:2], 3'b000} +: 8];
      gl[l]  = {1'b0, glyph_bits(ch[l])};
      bi[l]  = 4'(4'd14 - 4'(pr2_r[l][2:0]) * 4'd3 - {2'b00, pc2_r[l][1:0]});
      hit[l] = ge2_r[l] && (pc2_r[l][11:2] < 10'(geo.line[l].n)) &&
               (pc2_r[l][1:0] != 2'd3) && (pr2_r[l] < 12'd5) && gl[l][bi[l]];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out3_r <= out2_r;
      brd3_r <= brd2_r;
      hit3_r <= hit;
      for (int i = 0; i < 3; i++) begin
        g3_r[i] <= pg[i][43:36];
      end
    end
  end

  // stage 4: layering
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      priority if (out3_r) begin
        rgb[i] = 8'd0;
      end else if (hit3_r[1]) begin
        rgb[i] = 8'd220;
      end else if (hit3_r[0]) begin
        rgb[i] = 8'd255;
      end else if (brd3_r) begin
        rgb[i] = 8'd20;
      end else begin
        rgb[i] = geo.dark[i] + g3_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      red_r   <= rgb[0];
      green_r <= rgb[1];
      blue_r  <= rgb[2];
    end
  end

  assign out_valid = v4_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

  `GTP_ASSERT(a_stage_fill, clk, rst_n, $rose(v4_r) |-> $past(v3_r))
  `GTP_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !v4_r)

endmodule

// ----- src/gradient_text_pixel_generator_top.sv -----
// each accepted pixel word is registered through stages 1 to 4 before its result word leaves
// throughput: one pixel per cycle through the four-stage pixel pipeline unless out_rgb.ready stalls it
// reset and every config write rerun the layout sequencer (five serial
// divisions of 37 steps each); input ready stays low meanwhile
// reset: synchronous active-low rst_n, registers return to size 256, rest 0
module gradient_text_pixel_generator_top import gtp_pkg::*; #(
  parameter int MAX_SIZE     = 4096,
  parameter int MAX_LINE_LEN = 16
) (
  input logic       clk,
  input logic       rst_n,
  gtp_pix_if.sink   in_pix,
  gtp_rgb_if.source out_rgb,
  gtp_cfg_if.sink   cfg_wr
);

  geo_t geo;
  logic geo_ok;
  logic pipe_ready;
  logic cfg_rdy;

  gtp_cfg #(
    .MAX_SIZE     (MAX_SIZE),
    .MAX_LINE_LEN (MAX_LINE_LEN)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_wr.valid),
    .cfg_index (cfg_wr.index),
    .cfg_data  (cfg_wr.data),
    .cfg_ready (cfg_rdy),
    .geo       (geo),
    .geo_ok    (geo_ok)
  );

  gtp_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid && geo_ok),
    .in_ready  (pipe_ready),
    .pixel_x   (in_pix.pixel_x),
    .pixel_y   (in_pix.pixel_y),
    .geo       (geo),
    .out_valid (out_rgb.valid),
    .out_ready (out_rgb.ready),
    .red       (out_rgb.red),
    .green     (out_rgb.green),
    .blue      (out_rgb.blue)
  );

  assign cfg_wr.ready = cfg_rdy;
  assign in_pix.ready = pipe_ready && geo_ok;

endmodule
